>>> rtl/pus_pkg.sv
// Shared types, widths and constants of the particle update step.
`default_nettype none

package pus_pkg;

  // Store geometry
  localparam int PARTICLE_COUNT = 1024;
  localparam int ADDR_W = $clog2(PARTICLE_COUNT);

  // Field widths
  localparam int INDEX_W = 10;
  localparam int POS_W = 24;
  localparam int SIZE_W = 24;
  localparam int CH_W = 12;
  localparam int COL_W = 3 * CH_W;
  localparam int AGE_W = 9;
  localparam int SPAWN_W = 9;
  localparam int SPEED_W = 13;
  localparam int SPH_W = 14;
  localparam int LIFE_ROLL_W = 8;
  localparam int GROW_W = 12;
  localparam int SPREAD_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // Q12 arithmetic
  localparam int FRAC = 12;
  localparam int Q_HALF = 2048;
  localparam int Q_GRAV = 2009;     // 9.81 * 0.1 * 0.5
  localparam int Q_DT = 410;        // 0.1
  localparam int Q_SIZE0 = 41;      // 0.01
  localparam int DORMANT_Y = 4;     // 0.001
  localparam int SPAWN_LIMIT = 450;
  localparam int LIFE_BASE = 100;
  localparam int S24_MAX = 8388607;
  localparam int S24_MIN = -8388608;

  // Emission product widths
  localparam int DIR_PROD_W = POS_W + SPEED_W + 1;
  localparam int SPH_PROD_W = SPH_W + SPREAD_W + 1;
  localparam int DIR_TERM_W = DIR_PROD_W - FRAC;
  localparam int SPH_TERM_W = SPH_PROD_W - FRAC;
  localparam int SUM_W = DIR_TERM_W + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 2'd3;

  // One stored particle
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic signed [POS_W-1:0] vel_z;
    logic [COL_W-1:0]        colour;
    logic [SIZE_W-1:0]       size;
    logic [AGE_W-1:0]        age;
    logic [AGE_W-1:0]        lifespan;
  } part_t;

  // Emission settings
  typedef struct packed {
    logic signed [POS_W-1:0] dir_x;
    logic signed [POS_W-1:0] dir_y;
    logic signed [POS_W-1:0] dir_z;
    logic [SPREAD_W-1:0]     spread;
  } cfg_t;

  // One input word as carried down the pipeline
  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic [SPAWN_W-1:0]      spawn;
    logic [SPEED_W-1:0]      speed;
    logic signed [SPH_W-1:0] sph_x;
    logic signed [SPH_W-1:0] sph_y;
    logic signed [SPH_W-1:0] sph_z;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
    logic [LIFE_ROLL_W-1:0]  life_roll;
    logic [GROW_W-1:0]       grow;
  } item_t;

  // Rounded emission velocity terms
  typedef struct packed {
    logic signed [DIR_TERM_W-1:0] ex;
    logic signed [DIR_TERM_W-1:0] ey;
    logic signed [DIR_TERM_W-1:0] ez;
    logic signed [SPH_TERM_W-1:0] sx;
    logic signed [SPH_TERM_W-1:0] sy;
    logic signed [SPH_TERM_W-1:0] sz;
  } emit_t;

  localparam part_t PART_RESET = '{
    pos_x: '0, pos_y: POS_W'(DORMANT_Y), pos_z: '0,
    vel_x: '0, vel_y: '0, vel_z: '0,
    colour: '0, size: '0, age: '0, lifespan: AGE_W'(LIFE_BASE)
  };

  localparam cfg_t CFG_RESET = '{
    dir_x: '0, dir_y: POS_W'(4096), dir_z: '0, spread: SPREAD_W'(4096)
  };

endpackage

`default_nettype wire

>>> rtl/pus_in_if.sv
// Input channel: one particle update request per word.
`default_nettype none

interface pus_in_if;
  import pus_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [INDEX_W-1:0]            particle_index;
  logic [SPAWN_W-1:0]            spawn_roll;
  logic [SPEED_W-1:0]            speed_roll;
  logic signed [SPH_W-1:0]       sphere_x;
  logic signed [SPH_W-1:0]       sphere_y;
  logic signed [SPH_W-1:0]       sphere_z;
  logic [CH_W-1:0]               roll_red;
  logic [CH_W-1:0]               roll_green;
  logic [CH_W-1:0]               roll_blue;
  logic [LIFE_ROLL_W-1:0]        life_roll;
  logic [GROW_W-1:0]             size_roll;

  modport source (
    output valid, particle_index, spawn_roll, speed_roll, sphere_x, sphere_y, sphere_z,
           roll_red, roll_green, roll_blue, life_roll, size_roll,
    input  ready
  );

  modport sink (
    input  valid, particle_index, spawn_roll, speed_roll, sphere_x, sphere_y, sphere_z,
           roll_red, roll_green, roll_blue, life_roll, size_roll,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/pus_out_if.sv
// Result channel: the updated particle, one word per request.
`default_nettype none

interface pus_out_if;
  import pus_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;
  logic [COL_W-1:0]        out_colour;
  logic [SIZE_W-1:0]       out_size;
  logic                    respawned;

  modport source (
    output valid, out_pos_x, out_pos_y, out_pos_z, out_colour, out_size, respawned,
    input  ready
  );

  modport sink (
    input  valid, out_pos_x, out_pos_y, out_pos_z, out_colour, out_size, respawned,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/pus_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface pus_cfg_if;
  import pus_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/pus_cfg_regs.sv
// Emission configuration registers.
`default_nettype none

module pus_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [pus_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  logic [pus_pkg::CFG_DATA_W-1:0]   wr_data,
  output pus_pkg::cfg_t                    cfg
);
  import pus_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_EMIT_X: cfg_nxt.dir_x = wr_data;
        REG_EMIT_Y: cfg_nxt.dir_y = wr_data;
        REG_EMIT_Z: cfg_nxt.dir_z = wr_data;
        REG_SPREAD: cfg_nxt.spread = wr_data[SPREAD_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/pus_store.sv
// Particle state memory with registered read and a clearing pass after reset.
`default_nettype none

module pus_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [pus_pkg::ADDR_W-1:0]   rd_addr,
  output pus_pkg::part_t               rd_data,
  input  logic                         wr_en,
  input  logic [pus_pkg::ADDR_W-1:0]   wr_addr,
  input  pus_pkg::part_t               wr_data,
  output logic                         busy
);
  import pus_pkg::*;

  part_t             mem [PARTICLE_COUNT];
  part_t             rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              busy_r;

  // Memory port: clearing pass has priority over update writes
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= PART_RESET;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Clearing pass, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(PARTICLE_COUNT - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

`default_nettype wire

>>> rtl/pus_emit.sv
// Emission velocity terms: direction times speed and sphere times spread, Q12 rounded.
`default_nettype none

module pus_emit (
  input  pus_pkg::cfg_t  cfg,
  input  pus_pkg::item_t item,
  output pus_pkg::emit_t em
);
  import pus_pkg::*;

  logic signed [DIR_PROD_W-1:0] speed_s;
  logic signed [SPH_PROD_W-1:0] spread_s;
  logic signed [DIR_PROD_W-1:0] px, py, pz;
  logic signed [SPH_PROD_W-1:0] qx, qy, qz;

  assign speed_s  = DIR_PROD_W'($signed({1'b0, item.speed}));
  assign spread_s = SPH_PROD_W'($signed({1'b0, cfg.spread}));

  // Direction times speed, round half up
  assign px = DIR_PROD_W'(cfg.dir_x) * speed_s + DIR_PROD_W'(Q_HALF);
  assign py = DIR_PROD_W'(cfg.dir_y) * speed_s + DIR_PROD_W'(Q_HALF);
  assign pz = DIR_PROD_W'(cfg.dir_z) * speed_s + DIR_PROD_W'(Q_HALF);

  // Sphere vector times spread, round half up
  assign qx = SPH_PROD_W'(item.sph_x) * spread_s + SPH_PROD_W'(Q_HALF);
  assign qy = SPH_PROD_W'(item.sph_y) * spread_s + SPH_PROD_W'(Q_HALF);
  assign qz = SPH_PROD_W'(item.sph_z) * spread_s + SPH_PROD_W'(Q_HALF);

  assign em.ex = px[DIR_PROD_W-1:FRAC];
  assign em.ey = py[DIR_PROD_W-1:FRAC];
  assign em.ez = pz[DIR_PROD_W-1:FRAC];
  assign em.sx = qx[SPH_PROD_W-1:FRAC];
  assign em.sy = qy[SPH_PROD_W-1:FRAC];
  assign em.sz = qz[SPH_PROD_W-1:FRAC];

endmodule

`default_nettype wire

>>> rtl/pus_update.sv
// One Euler step of a particle: gravity, motion, growth, aging, respawn and bounce.
`default_nettype none

module pus_update (
  input  pus_pkg::part_t cur,
  input  pus_pkg::item_t item,
  input  pus_pkg::emit_t em,
  output pus_pkg::part_t nxt,
  output logic           resp
);
  import pus_pkg::*;

  // Clamp to 24-bit signed
  function automatic logic signed [POS_W-1:0] sat_s24(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(S24_MAX)) begin
      return POS_W'(S24_MAX);
    end else if (v < SUM_W'(S24_MIN)) begin
      return POS_W'(S24_MIN);
    end
    return v[POS_W-1:0];
  endfunction

  // Velocity times 0.1, round half up
  function automatic logic signed [POS_W+11-FRAC-1:0] qmul_dt(input logic signed [POS_W-1:0] v);
    logic signed [POS_W+11-1:0] p;
    p = (POS_W+11)'(v) * (POS_W+11)'(Q_DT) + (POS_W+11)'(Q_HALF);
    return p[POS_W+11-1:FRAC];
  endfunction

  logic signed [POS_W-1:0] vy_dec, px1, py1, pz1;
  logic signed [POS_W-1:0] vx_e, vy_e, vz_e;
  logic signed [SUM_W-1:0] vy_raw, vy_abs;
  logic [SIZE_W:0]         size_sum;
  logic [SIZE_W-1:0]       size1;
  logic [AGE_W:0]          age_inc;
  logic                    emit_on;

  // Gravity, then motion
  assign vy_dec = sat_s24(SUM_W'(cur.vel_y) - SUM_W'(Q_GRAV));
  assign px1 = sat_s24(SUM_W'(cur.pos_x) + SUM_W'(qmul_dt(cur.vel_x)));
  assign py1 = sat_s24(SUM_W'(cur.pos_y) + SUM_W'(qmul_dt(vy_dec)));
  assign pz1 = sat_s24(SUM_W'(cur.pos_z) + SUM_W'(qmul_dt(cur.vel_z)));

  // Growth and aging
  assign size_sum = {1'b0, cur.size} + (SIZE_W+1)'(item.grow);
  assign size1    = size_sum[SIZE_W] ? '1 : size_sum[SIZE_W-1:0];
  assign age_inc  = {1'b0, cur.age} + (AGE_W+1)'(1);
  assign emit_on  = item.spawn > SPAWN_W'(SPAWN_LIMIT);

  // Emission velocity, y folded upward
  assign vx_e   = sat_s24(SUM_W'(em.ex) + SUM_W'(em.sx));
  assign vy_raw = SUM_W'(em.ey) + SUM_W'(em.sy);
  assign vy_abs = vy_raw[SUM_W-1] ? -vy_raw : vy_raw;
  assign vy_e   = sat_s24(vy_abs);
  assign vz_e   = sat_s24(SUM_W'(em.ez) + SUM_W'(em.sz));

  // Select the new state
  always_comb begin
    nxt        = cur;
    nxt.pos_x  = px1;
    nxt.pos_y  = py1;
    nxt.pos_z  = pz1;
    nxt.vel_y  = vy_dec;
    nxt.size   = size1;
    nxt.age    = age_inc[AGE_W-1:0];
    resp       = age_inc >= {1'b0, cur.lifespan};
    if (resp) begin
      nxt.age = '0;
      if (emit_on) begin
        nxt.pos_x    = '0;
        nxt.pos_y    = '0;
        nxt.pos_z    = '0;
        nxt.vel_x    = vx_e;
        nxt.vel_y    = vy_e;
        nxt.vel_z    = vz_e;
        nxt.colour   = {item.red, item.green, item.blue};
        nxt.lifespan = AGE_W'(LIFE_BASE) + AGE_W'(item.life_roll);
        nxt.size     = SIZE_W'(Q_SIZE0);
      end else begin
        nxt.pos_x    = '0;
        nxt.pos_y    = POS_W'(DORMANT_Y);
        nxt.pos_z    = '0;
        nxt.vel_x    = '0;
        nxt.vel_y    = '0;
        nxt.vel_z    = '0;
        nxt.lifespan = AGE_W'(LIFE_BASE);
      end
    end else if (py1[POS_W-1] || py1 == '0) begin
      // bounce off the floor
      nxt.pos_y = sat_s24(-SUM_W'(py1));
      nxt.vel_y = sat_s24(-SUM_W'(vy_dec));
    end
  end

endmodule

`default_nettype wire

>>> rtl/particle_update_step.sv
// Particle update step top level: pipeline control, state forwarding and result register.
//
// in_ch carries one update word: the particle index and the random rolls for this
// step. Each accepted word reads the particle from the state memory, advances it by
// one Euler step (respawning it when its age reaches its lifespan) and writes it back.
// out_ch returns the updated position, colour, size and a respawn flag, one word per
// input word, in input order. cfg_ch writes the emission direction and spread; it is
// always ready. The user must write it only while no update is in flight; the block
// itself does not enforce this. The memory read happens at the accepting edge, the
// emission products are registered when the word leaves stage 1, and the update
// writes the memory and the output register when the word leaves stage 2.
// One word is accepted per cycle unless out_ch stalls; the memory read and write ports
// each carry one access per cycle, and back-to-back words on the same particle are
// served by forwarding the freshest state into the update stage.
// After reset the memory is cleared to dormant particles, one entry per cycle; in_ch
// is held not ready until the clearing pass is done. Emission settings reset to direction
// (0, 1, 0) and spread 1. When out_ch stalls, the pipeline keeps filling its empty
// stages and then holds, deasserting in_ch.ready.
`default_nettype none

module particle_update_step (
  input  logic      clk,
  input  logic      rst_n,
  pus_in_if.sink    in_ch,
  pus_out_if.source out_ch,
  pus_cfg_if.sink   cfg_ch
);
  import pus_pkg::*;

  cfg_t              cfg;
  item_t             in_item;
  part_t             rd_part;
  part_t             fwd_part;
  part_t             upd_part;
  emit_t             emit;
  logic              upd_resp;
  logic              clr_busy;

  logic              s1_v_r, s1_v_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic              wb_v_r, wb_v_nxt;
  item_t             s1_item_r;
  item_t             s2_item_r;
  emit_t             s2_emit_r;
  part_t             s2_part_r;
  part_t             out_part_r;
  logic              out_resp_r;
  logic [ADDR_W-1:0] wb_idx_r;
  part_t             wb_part_r;

  logic              in_acc, s1_adv, s2_adv, s1_load, s2_load;

  // Configuration
  assign cfg_ch.ready = 1'b1;

  pus_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  // Input word
  always_comb begin
    in_item.addr      = in_ch.particle_index[ADDR_W-1:0];
    in_item.spawn     = in_ch.spawn_roll;
    in_item.speed     = in_ch.speed_roll;
    in_item.sph_x     = in_ch.sphere_x;
    in_item.sph_y     = in_ch.sphere_y;
    in_item.sph_z     = in_ch.sphere_z;
    in_item.red       = in_ch.roll_red;
    in_item.green     = in_ch.roll_green;
    in_item.blue      = in_ch.roll_blue;
    in_item.life_roll = in_ch.life_roll;
    in_item.grow      = in_ch.size_roll;
  end

  // Stage handshakes
  assign s2_adv      = s2_v_r && (!out_v_r || out_ch.ready);
  assign s2_load     = !s2_v_r || s2_adv;
  assign s1_adv      = s1_v_r && s2_load;
  assign s1_load     = !s1_v_r || s1_adv;
  assign in_ch.ready = s1_load && !clr_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;

  pus_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_item.addr),
    .rd_data (rd_part),
    .wr_en   (s2_adv),
    .wr_addr (s2_item_r.addr),
    .wr_data (upd_part),
    .busy    (clr_busy)
  );

  pus_emit u_emit (
    .cfg  (cfg),
    .item (s1_item_r),
    .em   (emit)
  );

  // Freshest state: the write leaving now, then the last write, then memory
  always_comb begin
    fwd_part = rd_part;
    if (wb_v_r && wb_idx_r == s1_item_r.addr) begin
      fwd_part = wb_part_r;
    end
    if (s2_adv && s2_item_r.addr == s1_item_r.addr) begin
      fwd_part = upd_part;
    end
  end

  pus_update u_update (
    .cur  (s2_part_r),
    .item (s2_item_r),
    .em   (s2_emit_r),
    .nxt  (upd_part),
    .resp (upd_resp)
  );

  // Valid flags
  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
    out_v_nxt = s2_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
    wb_v_nxt  = wb_v_r || s2_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      wb_v_r  <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      wb_v_r  <= wb_v_nxt;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      s2_item_r <= s1_item_r;
      s2_emit_r <= emit;
      s2_part_r <= fwd_part;
    end
    if (s2_adv) begin
      out_part_r <= upd_part;
      out_resp_r <= upd_resp;
      wb_idx_r   <= s2_item_r.addr;
      wb_part_r  <= upd_part;
    end
  end

  // Result word
  assign out_ch.valid      = out_v_r;
  assign out_ch.out_pos_x  = out_part_r.pos_x;
  assign out_ch.out_pos_y  = out_part_r.pos_y;
  assign out_ch.out_pos_z  = out_part_r.pos_z;
  assign out_ch.out_colour = out_part_r.colour;
  assign out_ch.out_size   = out_part_r.size;
  assign out_ch.respawned  = out_resp_r;

  // Checks
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> s2_v_r)
    else $error("word left stage 1 but stage 2 is empty");

  a_y_not_below_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |-> !upd_part.pos_y[POS_W-1])
    else $error("written y position is below the floor");

  a_respawn_age: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && upd_resp) |-> (upd_part.age == '0))
    else $error("respawned particle kept its age");

  a_emit_upward: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && upd_resp && s2_item_r.spawn > SPAWN_W'(SPAWN_LIMIT))
      |-> !upd_part.vel_y[POS_W-1])
    else $error("emitted particle moves downward");

endmodule

`default_nettype wire
